>>> hw/rtl/aces_filmic_tonemap_core_defines.svh
// Assertion macros used by the tone mapping core RTL (aft_merge).
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ACES_FILMIC_TONEMAP_CORE_DEFINES_SVH
`define ACES_FILMIC_TONEMAP_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define AFT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define AFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define AFT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define AFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hw/rtl/aft_pkg.sv
`timescale 1ns / 1ps
// Widths, coefficients and the pixel type of the filmic tone mapping core.
// No dependencies.
package aft_pkg;

	localparam int unsigned IN_FRAC_DEF  = 12;
	localparam int unsigned OUT_FRAC_DEF = 12;

	localparam int unsigned NLANE = 3;
	localparam int unsigned CH_W  = 16;
	localparam int unsigned COL_W = 13;
	localparam int unsigned TN_W  = 25;
	localparam int unsigned PROD_W = 41;
	localparam int unsigned REM_W = PROD_W + 1;

	localparam int unsigned COEF_A = 251;
	localparam int unsigned COEF_B = 3;
	localparam int unsigned COEF_C = 243;
	localparam int unsigned COEF_D = 59;
	localparam int unsigned COEF_E = 14;

	typedef struct packed {
		logic [CH_W-1:0]  alpha;
		logic [COL_W-1:0] blue;
		logic [COL_W-1:0] green;
		logic [COL_W-1:0] red;
	} pix_t;

endpackage

>>> hw/rtl/aces_filmic_tonemap_core.sv
`timescale 1ns / 1ps
// Top level of the filmic tone mapping core: three colour lanes and merge.
// Depends on aft_pkg, aft_lane and aft_merge.
//
// Channel  Handshake              Payload
// input    in_valid / in_stall    red_in green_in blue_in alpha_in
// output   out_valid / out_stall  red_out green_out blue_out alpha_out
//
// One request per clock while in_stall is low.
// The restoring divider gives one quotient bit per stage per lane.
// in_stall rises only while the output skid slot is full; it is registered.
// Reset clears the valid bits only; no clearing pass.
module aces_filmic_tonemap_core #(
	parameter int unsigned INPUT_FRAC_BITS  = aft_pkg::IN_FRAC_DEF,
	parameter int unsigned OUTPUT_FRAC_BITS = aft_pkg::OUT_FRAC_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [aft_pkg::CH_W-1:0]  red_in,
	input  logic [aft_pkg::CH_W-1:0]  green_in,
	input  logic [aft_pkg::CH_W-1:0]  blue_in,
	input  logic [aft_pkg::CH_W-1:0]  alpha_in,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [aft_pkg::COL_W-1:0] red_out,
	output logic [aft_pkg::COL_W-1:0] green_out,
	output logic [aft_pkg::COL_W-1:0] blue_out,
	output logic [aft_pkg::CH_W-1:0]  alpha_out
);
	import aft_pkg::*;

	localparam int unsigned LAT = OUTPUT_FRAC_BITS + 4;

	logic                      adv;
	logic [LAT-1:0]            vld_q;
	logic [CH_W-1:0]           alpha_q [LAT];
	logic [CH_W-1:0]           chan [NLANE];
	logic [OUTPUT_FRAC_BITS:0] quo [NLANE];
	logic                      sat [NLANE];

	assign chan[0]  = red_in;
	assign chan[1]  = green_in;
	assign chan[2]  = blue_in;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			alpha_q[0] <= alpha_in;
			for (int i = 1; i < LAT; i++) begin
				alpha_q[i] <= alpha_q[i-1];
			end
		end
	end

	for (genvar l = 0; l < NLANE; l++) begin : g_lane
		aft_lane #(
			.INPUT_FRAC_BITS (INPUT_FRAC_BITS),
			.OUTPUT_FRAC_BITS(OUTPUT_FRAC_BITS)
		) u_lane (
			.clk(clk),
			.en (adv),
			.x  (chan[l]),
			.quo(quo[l]),
			.sat(sat[l])
		);
	end

	aft_merge #(
		.OUTPUT_FRAC_BITS(OUTPUT_FRAC_BITS)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_vld (vld_q[LAT-1]),
		.quo      (quo),
		.sat      (sat),
		.alpha    (alpha_q[LAT-1]),
		.out_stall(out_stall),
		.adv      (adv),
		.out_valid(out_valid),
		.red_out  (red_out),
		.green_out(green_out),
		.blue_out (blue_out),
		.alpha_out(alpha_out)
	);

endmodule

>>> hw/rtl/aft_poly.sv
`timescale 1ns / 1ps
// Numerator and denominator polynomials of one colour lane, three stages.
// Depends on aft_pkg.
module aft_poly #(
	parameter int unsigned INPUT_FRAC_BITS  = aft_pkg::IN_FRAC_DEF,
	parameter int unsigned OUTPUT_FRAC_BITS = aft_pkg::OUT_FRAC_DEF
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic [aft_pkg::CH_W-1:0]               x,
	output logic [aft_pkg::REM_W-1:0]              rem_s3,
	output logic [aft_pkg::PROD_W-1:0]             den_s3,
	output logic [OUTPUT_FRAC_BITS:0]              lo_s3,
	output logic                                   sat_s3
);
	import aft_pkg::*;

	localparam int unsigned Q = OUTPUT_FRAC_BITS + 1;
	localparam logic [TN_W-1:0]   OFS_N = TN_W'(COEF_B) << INPUT_FRAC_BITS;
	localparam logic [TN_W-1:0]   OFS_D = TN_W'(COEF_D) << INPUT_FRAC_BITS;
	localparam logic [PROD_W-1:0] OFS_E = PROD_W'(COEF_E) << (2 * INPUT_FRAC_BITS);

	logic [CH_W-1:0]   x_s1;
	logic [TN_W-1:0]   tn_s1;
	logic [TN_W-1:0]   td_s1;
	logic [PROD_W-1:0] num_s2;
	logic [PROD_W-1:0] den_s2;
	logic [TN_W-1:0]   x_w;
	logic [PROD_W-1:0] mul_num;
	logic [PROD_W-1:0] mul_den;

	assign x_w     = TN_W'(x);
	assign mul_num = PROD_W'(x_s1) * PROD_W'(tn_s1);
	assign mul_den = PROD_W'(x_s1) * PROD_W'(td_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= x;
			tn_s1  <= x_w * TN_W'(COEF_A) + OFS_N;
			td_s1  <= x_w * TN_W'(COEF_C) + OFS_D;
			num_s2 <= mul_num;
			den_s2 <= mul_den + OFS_E;
			sat_s3 <= (num_s2 >= den_s2);
			rem_s3 <= REM_W'(num_s2) + REM_W'(den_s2 >> Q);
			lo_s3  <= den_s2[Q-1:0];
			den_s3 <= den_s2;
		end
	end

endmodule

>>> hw/rtl/aft_div_step.sv
`timescale 1ns / 1ps
// One restoring division stage: one quotient bit per clock while en is high.
// Depends on aft_pkg.
module aft_div_step #(
	parameter int unsigned OUTPUT_FRAC_BITS = aft_pkg::OUT_FRAC_DEF
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [aft_pkg::REM_W-1:0]  rem_i,
	input  logic [aft_pkg::PROD_W-1:0] den_i,
	input  logic [OUTPUT_FRAC_BITS:0]  lo_i,
	input  logic [OUTPUT_FRAC_BITS:0]  quo_i,
	input  logic                       sat_i,
	output logic [aft_pkg::REM_W-1:0]  rem_q,
	output logic [aft_pkg::PROD_W-1:0] den_q,
	output logic [OUTPUT_FRAC_BITS:0]  lo_q,
	output logic [OUTPUT_FRAC_BITS:0]  quo_q,
	output logic                       sat_q
);
	import aft_pkg::*;

	localparam int unsigned Q = OUTPUT_FRAC_BITS + 1;

	logic [REM_W:0] trial;
	logic [REM_W:0] dvs;
	logic [REM_W:0] diff;
	logic           ge;

	assign trial = {rem_i, lo_i[Q-1]};
	assign dvs   = {1'b0, den_i, 1'b0};
	assign diff  = trial - dvs;
	assign ge    = (trial >= dvs);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
			den_q <= den_i;
			lo_q  <= {lo_i[Q-2:0], 1'b0};
			quo_q <= {quo_i[Q-2:0], ge};
			sat_q <= sat_i;
		end
	end

endmodule

>>> hw/rtl/aft_lane.sv
`timescale 1ns / 1ps
// One colour lane: polynomial stages followed by the divider pipeline.
// Depends on aft_pkg, aft_poly and aft_div_step.
module aft_lane #(
	parameter int unsigned INPUT_FRAC_BITS  = aft_pkg::IN_FRAC_DEF,
	parameter int unsigned OUTPUT_FRAC_BITS = aft_pkg::OUT_FRAC_DEF
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [aft_pkg::CH_W-1:0]  x,
	output logic [OUTPUT_FRAC_BITS:0] quo,
	output logic                      sat
);
	import aft_pkg::*;

	localparam int unsigned Q = OUTPUT_FRAC_BITS + 1;

	logic [REM_W-1:0]        rem_w [Q+1];
	logic [PROD_W-1:0]       den_w [Q+1];
	logic [OUTPUT_FRAC_BITS:0] lo_w  [Q+1];
	logic [OUTPUT_FRAC_BITS:0] quo_w [Q+1];
	logic                    sat_w [Q+1];

	aft_poly #(
		.INPUT_FRAC_BITS (INPUT_FRAC_BITS),
		.OUTPUT_FRAC_BITS(OUTPUT_FRAC_BITS)
	) u_poly (
		.clk   (clk),
		.en    (en),
		.x     (x),
		.rem_s3(rem_w[0]),
		.den_s3(den_w[0]),
		.lo_s3 (lo_w[0]),
		.sat_s3(sat_w[0])
	);

	assign quo_w[0] = '0;

	for (genvar i = 0; i < Q; i++) begin : g_step
		aft_div_step #(
			.OUTPUT_FRAC_BITS(OUTPUT_FRAC_BITS)
		) u_step (
			.clk  (clk),
			.en   (en),
			.rem_i(rem_w[i]),
			.den_i(den_w[i]),
			.lo_i (lo_w[i]),
			.quo_i(quo_w[i]),
			.sat_i(sat_w[i]),
			.rem_q(rem_w[i+1]),
			.den_q(den_w[i+1]),
			.lo_q (lo_w[i+1]),
			.quo_q(quo_w[i+1]),
			.sat_q(sat_w[i+1])
		);
	end

	assign quo = quo_w[Q];
	assign sat = sat_w[Q];

endmodule

>>> hw/rtl/aft_merge.sv
`timescale 1ns / 1ps
// Merges the lanes and alpha into one request; output register and skid slot.
// Depends on aft_pkg and aces_filmic_tonemap_core_defines.svh.
`include "aces_filmic_tonemap_core_defines.svh"
module aft_merge #(
	parameter int unsigned OUTPUT_FRAC_BITS = aft_pkg::OUT_FRAC_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push_vld,
	input  logic [OUTPUT_FRAC_BITS:0]  quo [aft_pkg::NLANE],
	input  logic                       sat [aft_pkg::NLANE],
	input  logic [aft_pkg::CH_W-1:0]   alpha,
	input  logic                       out_stall,
	output logic                       adv,
	output logic                       out_valid,
	output logic [aft_pkg::COL_W-1:0]  red_out,
	output logic [aft_pkg::COL_W-1:0]  green_out,
	output logic [aft_pkg::COL_W-1:0]  blue_out,
	output logic [aft_pkg::CH_W-1:0]   alpha_out
);
	import aft_pkg::*;

	localparam int unsigned Q  = OUTPUT_FRAC_BITS + 1;
	localparam int unsigned EW = (Q > COL_W) ? Q : COL_W;
	localparam logic [EW-1:0]    ONE_EXT = EW'(1) << OUTPUT_FRAC_BITS;
	localparam logic [COL_W-1:0] ONE_COL = ONE_EXT[COL_W-1:0];

	logic [COL_W-1:0] col [NLANE];
	logic [EW-1:0]    ext [NLANE];
	pix_t             pix_new;
	pix_t             out_q;
	pix_t             skid_q;
	logic             out_valid_q;
	logic             skid_valid_q;

	for (genvar l = 0; l < NLANE; l++) begin : g_clamp
		assign ext[l] = sat[l] ? ONE_EXT : EW'(quo[l]);
		assign col[l] = ext[l][COL_W-1:0];
	end

	assign pix_new.red   = col[0];
	assign pix_new.green = col[1];
	assign pix_new.blue  = col[2];
	assign pix_new.alpha = alpha;

	assign adv = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (!out_stall) begin
				skid_valid_q <= 1'b0;
			end
		end else if (out_valid_q && out_stall) begin
			if (push_vld) begin
				skid_valid_q <= 1'b1;
			end
		end else begin
			out_valid_q <= push_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (!out_stall) begin
				out_q <= skid_q;
			end
		end else if (out_valid_q && out_stall) begin
			if (push_vld) begin
				skid_q <= pix_new;
			end
		end else begin
			out_q <= pix_new;
		end
	end

	assign out_valid = out_valid_q;
	assign red_out   = out_q.red;
	assign green_out = out_q.green;
	assign blue_out  = out_q.blue;
	assign alpha_out = out_q.alpha;

	`AFT_ASSERT_IMPL(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q, "skid full while output empty")
	`AFT_ASSERT_NEXT(a_skid_catch, clk, arst_n, out_valid_q && out_stall && push_vld && !skid_valid_q, skid_valid_q && out_valid_q, "stalled request dropped")
	`AFT_ASSERT_NEXT(a_skid_drain, clk, arst_n, skid_valid_q && !out_stall, out_valid_q && !skid_valid_q, "skid not drained")
	`AFT_ASSERT_IMPL(a_red_range, clk, arst_n, out_valid_q, (OUTPUT_FRAC_BITS >= COL_W) || (out_q.red <= ONE_COL), "red above one")

endmodule
